[sv/rcm_pkg.sv]
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared sample types, field widths and defaults for the running median block.
// ----------------------------------------------------------------------------
package rcm_pkg;

  localparam int TEMP_W = 15;
  localparam int HUM_W  = 14;
  localparam int SOIL_W = 12;

  localparam int WINDOW_LENGTH_DEF = 11;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic        [HUM_W-1:0]  hum_t;
  typedef logic        [SOIL_W-1:0] soil_t;

endpackage

[sv/rcm_if.sv]
// ----------------------------------------------------------------------------
// rcm_in_if / rcm_out_if
// Valid/ready channels for sample sets and median results.
// ----------------------------------------------------------------------------
interface rcm_in_if;
  import rcm_pkg::*;

  logic  valid;
  logic  ready;
  temp_t temperature_sample;
  hum_t  humidity_sample;
  soil_t soil_sample;

  modport source (output valid, output temperature_sample, output humidity_sample,
                  output soil_sample, input ready);
  modport sink   (input valid, input temperature_sample, input humidity_sample,
                  input soil_sample, output ready);
endinterface

interface rcm_out_if;
  import rcm_pkg::*;

  logic  valid;
  logic  ready;
  temp_t temperature_median;
  hum_t  humidity_median;
  soil_t soil_median;

  modport source (output valid, output temperature_median, output humidity_median,
                  output soil_median, input ready);
  modport sink   (input valid, input temperature_median, input humidity_median,
                  input soil_median, output ready);
endinterface

[sv/rcm_ctrl.sv]
// ----------------------------------------------------------------------------
// rcm_ctrl
// Sequencer: stores the ring position, then walks every candidate entry
// against every stored entry so the lanes can rank each candidate.
// ----------------------------------------------------------------------------
module rcm_ctrl #(
  parameter int WINDOW_LENGTH = 11,
  parameter int AW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1,
  parameter int CW = $clog2(WINDOW_LENGTH + 1)
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_free,
  output logic out_load,
  output logic [2*AW+CW+3:0] lane_ctrl
);
  import rcm_pkg::*;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic          ld;
    logic          cmp;
    logic          last;
    logic [CW-1:0] k;
  } lane_ctrl_t;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam logic [CW-1:0] WIN_CNT = CW'(WINDOW_LENGTH);

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic          full_r, full_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic          cand_phase_r, cand_phase_nxt;

  logic [CW-1:0] pos_inc;
  logic [CW-1:0] last_idx;
  logic          accept;
  lane_ctrl_t    ctl;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign pos_inc  = CW'(pos_r) + CW'(1);
  assign last_idx = count_r - CW'(1);
  assign out_load = (state_r == S_DONE) && out_free;
  assign lane_ctrl = ctl;

  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    full_nxt       = full_r;
    count_nxt      = count_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    cand_phase_nxt = cand_phase_r;
    ctl.we         = accept;
    ctl.waddr      = pos_r;
    ctl.raddr      = j_r;
    ctl.ld         = 1'b0;
    ctl.cmp        = 1'b0;
    ctl.last       = 1'b0;
    ctl.k          = count_r >> 1;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          // advance and wrap the ring position; first wrap fills the window
          if (pos_inc == WIN_CNT) begin
            pos_nxt   = '0;
            full_nxt  = 1'b1;
            count_nxt = WIN_CNT;
          end else begin
            pos_nxt   = pos_inc[AW-1:0];
            count_nxt = full_r ? WIN_CNT : pos_inc;
          end
          i_nxt          = '0;
          j_nxt          = '0;
          cand_phase_nxt = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cand_phase_r) begin
          ctl.raddr      = i_r;
          ctl.ld         = 1'b1;
          cand_phase_nxt = 1'b0;
          j_nxt          = '0;
        end else begin
          ctl.raddr = j_r;
          ctl.cmp   = 1'b1;
          if (CW'(j_r) == last_idx) begin
            ctl.last       = 1'b1;
            j_nxt          = '0;
            cand_phase_nxt = 1'b1;
            if (CW'(i_r) == last_idx) begin
              state_nxt = S_DRAIN;
            end else begin
              i_nxt = i_r + AW'(1);
            end
          end else begin
            j_nxt = j_r + AW'(1);
          end
        end
      end
      S_DRAIN: begin
        // let the final compare settle in the lanes
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pos_r        <= '0;
      full_r       <= 1'b0;
      count_r      <= '0;
      i_r          <= '0;
      j_r          <= '0;
      cand_phase_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      full_r       <= full_nxt;
      count_r      <= count_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      cand_phase_r <= cand_phase_nxt;
    end
  end

endmodule

[sv/rcm_lane.sv]
// ----------------------------------------------------------------------------
// rcm_lane
// One channel: sample window memory and a rank counter. A candidate whose
// count of smaller entries is at most k and whose count of smaller-or-equal
// entries exceeds k is the k-th smallest value.
// ----------------------------------------------------------------------------
module rcm_lane #(
  parameter int   WINDOW_LENGTH = 11,
  parameter int   DATA_W        = 12,
  parameter logic SIGNED_CMP    = 1'b0,
  parameter int   AW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1,
  parameter int   CW = $clog2(WINDOW_LENGTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [2*AW+CW+3:0] lane_ctrl,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] median
);
  import rcm_pkg::*;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic          ld;
    logic          cmp;
    logic          last;
    logic [CW-1:0] k;
  } lane_ctrl_t;

  // flipping the sign bit turns a two's complement compare into an unsigned one
  localparam logic [DATA_W-1:0] FLIP = {SIGNED_CMP, {(DATA_W-1){1'b0}}};

  lane_ctrl_t        ctl;
  logic [DATA_W-1:0] mem [WINDOW_LENGTH];
  logic [DATA_W-1:0] rd_data_r;
  logic              ld_d_r, cmp_d_r, last_d_r;
  logic [DATA_W-1:0] cand_r;
  logic [CW-1:0]     less_r, le_r;
  logic [DATA_W-1:0] med_r;

  logic              lt, eq;
  logic [CW-1:0]     less_sum, le_sum;

  assign ctl    = lane_ctrl;
  assign median = med_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= wdata;
    end
    rd_data_r <= mem[ctl.raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_d_r   <= 1'b0;
      cmp_d_r  <= 1'b0;
      last_d_r <= 1'b0;
    end else begin
      ld_d_r   <= ctl.ld;
      cmp_d_r  <= ctl.cmp;
      last_d_r <= ctl.last;
    end
  end

  assign lt       = (rd_data_r ^ FLIP) < (cand_r ^ FLIP);
  assign eq       = (rd_data_r == cand_r);
  assign less_sum = less_r + CW'(lt);
  assign le_sum   = le_r + CW'(lt || eq);

  always_ff @(posedge clk) begin
    if (ld_d_r) begin
      cand_r <= rd_data_r;
      less_r <= '0;
      le_r   <= '0;
    end else if (cmp_d_r) begin
      less_r <= less_sum;
      le_r   <= le_sum;
      if (last_d_r && (less_sum <= ctl.k) && (le_sum > ctl.k)) begin
        med_r <= cand_r;
      end
    end
  end

endmodule

[sv/three_channel_running_median_top.sv]
// ----------------------------------------------------------------------------
// three_channel_running_median_top
// Running median filter over ring windows of temperature, humidity and soil
// samples with a shared ring position, one lane per channel.
//
// Usage: in_ch carries one sample set per request (valid/ready, accepted when
// both are high). Each request is written to the ring at the current position,
// the position advances and wraps, and the window counts as full after the
// first wrap. out_ch returns one result per request: the median of each
// channel over the full window, or over the entries written so far, taking
// the upper middle value for an even count.
// Scan: with n stored entries, each of the n candidates is loaded and then
// compared against all n entries through one read port per lane, followed by
// a drain state and the output load.
// in_ch.ready is high only when idle, so a new request is not accepted until
// the previous result has been loaded into the output register.
// A finished result sits in the output register; if the receiver stalls, the
// next request is still accepted and scanned, and it waits at the end of its
// scan until the register is free.
// Reset (rst_n low, synchronous) empties the window and drops any pending
// result; stored samples are not cleared.
// ----------------------------------------------------------------------------
module three_channel_running_median_top #(
  parameter int WINDOW_LENGTH = rcm_pkg::WINDOW_LENGTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rcm_in_if.sink    in_ch,
  rcm_out_if.source out_ch
);
  import rcm_pkg::*;

  localparam int AW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int CW = $clog2(WINDOW_LENGTH + 1);

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic          ld;
    logic          cmp;
    logic          last;
    logic [CW-1:0] k;
  } lane_ctrl_t;

  lane_ctrl_t        lane_ctrl;
  logic              out_free;
  logic              out_load;
  logic [TEMP_W-1:0] temp_med;
  logic [HUM_W-1:0]  hum_med;
  logic [SOIL_W-1:0] soil_med;

  logic  out_valid_r;
  temp_t temp_med_r;
  hum_t  hum_med_r;
  soil_t soil_med_r;

  assign out_free = !out_valid_r || out_ch.ready;

  rcm_ctrl #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .AW            (AW),
    .CW            (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_free  (out_free),
    .out_load  (out_load),
    .lane_ctrl (lane_ctrl)
  );

  rcm_lane #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .DATA_W        (TEMP_W),
    .SIGNED_CMP    (1'b1),
    .AW            (AW),
    .CW            (CW)
  ) u_lane_temp (
    .clk       (clk),
    .rst_n     (rst_n),
    .lane_ctrl (lane_ctrl),
    .wdata     (unsigned'(in_ch.temperature_sample)),
    .median    (temp_med)
  );

  rcm_lane #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .DATA_W        (HUM_W),
    .SIGNED_CMP    (1'b0),
    .AW            (AW),
    .CW            (CW)
  ) u_lane_hum (
    .clk       (clk),
    .rst_n     (rst_n),
    .lane_ctrl (lane_ctrl),
    .wdata     (in_ch.humidity_sample),
    .median    (hum_med)
  );

  rcm_lane #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .DATA_W        (SOIL_W),
    .SIGNED_CMP    (1'b0),
    .AW            (AW),
    .CW            (CW)
  ) u_lane_soil (
    .clk       (clk),
    .rst_n     (rst_n),
    .lane_ctrl (lane_ctrl),
    .wdata     (in_ch.soil_sample),
    .median    (soil_med)
  );

  // merge the three lane medians into one result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      temp_med_r <= signed'(temp_med);
      hum_med_r  <= hum_med;
      soil_med_r <= soil_med;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.temperature_median = temp_med_r;
  assign out_ch.humidity_median    = hum_med_r;
  assign out_ch.soil_median        = soil_med_r;

endmodule
